// ===== hw/rtl/crp_pkg.sv =====
package crp_pkg;

   localparam int DET_WIDTH = 40;
   localparam int PP_WIDTH = 32;
   localparam int FOCAL_WIDTH = 32;
   localparam int ROT_REG_WIDTH = 54;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int STATUS_WIDTH = 2;
   localparam int GROUND_WIDTH_DEF = 40;
   localparam int ROT_FRAC_BITS_DEF = 16;

   localparam logic [ROT_REG_WIDTH-1:0] ROT_ONE_RESET = 54'd65536;
   localparam logic [ROT_REG_WIDTH-1:0] ROT_TWO_RESET = 54'd17179869184;
   localparam logic [ROT_REG_WIDTH-1:0] ROT_THREE_RESET = 54'd4503599627370496;
   localparam logic [FOCAL_WIDTH-1:0] FOCAL_RESET = 32'd9830400;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ROT_ONE   = 3'd0,
      CSR_ROT_TWO   = 3'd1,
      CSR_ROT_THREE = 3'd2,
      CSR_STATION_X = 3'd3,
      CSR_STATION_Y = 3'd4,
      CSR_STATION_Z = 3'd5,
      CSR_PRINCIPAL = 3'd6,
      CSR_FOCAL     = 3'd7
   } csr_index_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ZERO_DEN = 2'd1,
      STATUS_SAT      = 2'd2
   } status_type;

   typedef struct packed {
      logic act;
      logic den_zero;
   } ctl_type;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   function automatic int dif_width(input int gw);
      return max_int(gw + 1, DET_WIDTH + 1);
   endfunction

   function automatic int fac_width(input int gw);
      return max_int(FOCAL_WIDTH + 1, gw + 1);
   endfunction

   function automatic int num_width(input int gw, input int rf);
      return rf + 2 + dif_width(gw) + 2;
   endfunction

   function automatic int prod_width(input int gw, input int rf);
      return num_width(gw, rf) + fac_width(gw);
   endfunction

   function automatic int quo_width(input int gw);
      return max_int(gw, DET_WIDTH) + 1;
   endfunction

   function automatic int base_width(input int gw);
      return max_int(gw, PP_WIDTH);
   endfunction

   function automatic int res_width(input int gw);
      return max_int(base_width(gw), quo_width(gw) + 1) + 2;
   endfunction

   function automatic int cmp_width(input int gw, input int rf);
      return max_int(prod_width(gw, rf), num_width(gw, rf) + quo_width(gw));
   endfunction

endpackage

// ===== hw/rtl/collinearity_ray_projection.sv =====
// channel   dir  handshake                 payload
// req       in   req_valid / req_stall     action, coord_first, coord_second, ground_height
// rsp       out  rsp_valid / rsp_stall     result_first, result_second, status
// csr       in   csr_we                    csr_index, csr_wdata
//
// one request per cycle sustained while the response is not stalled; the restoring divider
// resolves one quotient bit per stage
// reset clears all valid bits and loads the configuration reset values
// a stalled response holds each unbroken run of stages with requests behind it; bubbles close up
module collinearity_ray_projection #(
   parameter int GROUND_WIDTH = crp_pkg::GROUND_WIDTH_DEF,
   parameter int ROT_FRAC_BITS = crp_pkg::ROT_FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_action,
   input  logic signed [crp_pkg::DET_WIDTH-1:0] req_coord_first,
   input  logic signed [crp_pkg::DET_WIDTH-1:0] req_coord_second,
   input  logic signed [crp_pkg::DET_WIDTH-1:0] req_ground_height,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [crp_pkg::DET_WIDTH-1:0] rsp_result_first,
   output logic signed [crp_pkg::DET_WIDTH-1:0] rsp_result_second,
   output logic [crp_pkg::STATUS_WIDTH-1:0] rsp_status,
   input  logic csr_we,
   input  logic [crp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [crp_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);
   import crp_pkg::*;

   localparam int RW = ROT_FRAC_BITS + 2;
   localparam int RXW = max_int(ROT_REG_WIDTH, 3 * RW);
   localparam int NUMW = num_width(GROUND_WIDTH, ROT_FRAC_BITS);
   localparam int FW = fac_width(GROUND_WIDTH);
   localparam int BW = base_width(GROUND_WIDTH);
   localparam int PW = prod_width(GROUND_WIDTH, ROT_FRAC_BITS);
   localparam int RSW = res_width(GROUND_WIDTH);
   localparam logic signed [RSW-1:0] DET_MAX =
      {{(RSW-DET_WIDTH+1){1'b0}}, {(DET_WIDTH-1){1'b1}}};
   localparam logic signed [RSW-1:0] GND_MAX =
      {{(RSW-GROUND_WIDTH+1){1'b0}}, {(GROUND_WIDTH-1){1'b1}}};

   logic [ROT_REG_WIDTH-1:0] rot_ff [3];
   logic [DET_WIDTH-1:0]     station_x_ff, station_y_ff, station_z_ff;
   logic [CSR_DATA_WIDTH-1:0] principal_ff;
   logic [FOCAL_WIDTH-1:0]   focal_ff;

   logic [RXW-1:0]                 rot_ext [3];
   logic signed [RW-1:0]           rot_w [3][3];
   logic [63:0]                    stx64, sty64, stz64;
   logic signed [GROUND_WIDTH-1:0] st_x, st_y, st_z;
   logic signed [PP_WIDTH-1:0]     xi0, eta0;

   logic                   fr_valid, fr_stall, fr_action;
   logic signed [NUMW-1:0] fr_num [3];
   logic signed [FW-1:0]   fr_factor;
   logic signed [BW-1:0]   fr_base [2];

   logic                   sc_valid, sc_stall;
   ctl_type                sc_ctl;
   logic [PW-1:0]          sc_mag [2];
   logic                   sc_qneg [2], sc_ovf [2];
   logic [NUMW-1:0]        sc_dmag;
   logic signed [BW-1:0]   sc_base [2];

   logic                   dv_valid, dv_stall;
   ctl_type                dv_ctl;
   logic signed [RSW-1:0]  dv_res [2];

   logic signed [RSW-1:0]  lim;
   logic signed [RSW-1:0]  clip_w [2];
   logic                   sat [2];

   logic                   rsp_valid_ff;
   logic [DET_WIDTH-1:0]   rsp_first_ff, rsp_first_in;
   logic [DET_WIDTH-1:0]   rsp_second_ff, rsp_second_in;
   status_type             rsp_status_ff, rsp_status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0] <= ROT_ONE_RESET;
         rot_ff[1] <= ROT_TWO_RESET;
         rot_ff[2] <= ROT_THREE_RESET;
         station_x_ff <= '0;
         station_y_ff <= '0;
         station_z_ff <= '0;
         principal_ff <= '0;
         focal_ff <= FOCAL_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROT_ONE:   rot_ff[0] <= csr_wdata[ROT_REG_WIDTH-1:0];
            CSR_ROT_TWO:   rot_ff[1] <= csr_wdata[ROT_REG_WIDTH-1:0];
            CSR_ROT_THREE: rot_ff[2] <= csr_wdata[ROT_REG_WIDTH-1:0];
            CSR_STATION_X: station_x_ff <= csr_wdata[DET_WIDTH-1:0];
            CSR_STATION_Y: station_y_ff <= csr_wdata[DET_WIDTH-1:0];
            CSR_STATION_Z: station_z_ff <= csr_wdata[DET_WIDTH-1:0];
            CSR_PRINCIPAL: principal_ff <= csr_wdata;
            CSR_FOCAL:     focal_ff <= csr_wdata[FOCAL_WIDTH-1:0];
            default:       principal_ff <= principal_ff;
         endcase
      end
   end

   // fields beyond the register width read as zero
   always_comb begin
      for (int n = 0; n < 3; n++) begin
         rot_ext[n] = RXW'(rot_ff[n]);
         for (int k = 0; k < 3; k++) begin
            rot_w[n][k] = $signed(rot_ext[n][k*RW +: RW]);
         end
      end
      stx64 = 64'(station_x_ff);
      sty64 = 64'(station_y_ff);
      stz64 = 64'(station_z_ff);
      st_x = $signed(stx64[GROUND_WIDTH-1:0]);
      st_y = $signed(sty64[GROUND_WIDTH-1:0]);
      st_z = $signed(stz64[GROUND_WIDTH-1:0]);
      xi0 = $signed(principal_ff[PP_WIDTH-1:0]);
      eta0 = $signed(principal_ff[2*PP_WIDTH-1:PP_WIDTH]);
   end

   crp_front #(
      .GROUND_WIDTH(GROUND_WIDTH),
      .ROT_FRAC_BITS(ROT_FRAC_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .in_valid(req_valid),
      .in_stall(req_stall),
      .in_action(req_action),
      .in_first(req_coord_first),
      .in_second(req_coord_second),
      .in_height(req_ground_height),
      .rot(rot_w),
      .st_x(st_x),
      .st_y(st_y),
      .st_z(st_z),
      .xi0(xi0),
      .eta0(eta0),
      .focal(focal_ff),
      .out_valid(fr_valid),
      .out_stall(fr_stall),
      .out_action(fr_action),
      .num(fr_num),
      .factor(fr_factor),
      .base(fr_base)
   );

   crp_scale #(
      .GROUND_WIDTH(GROUND_WIDTH),
      .ROT_FRAC_BITS(ROT_FRAC_BITS)
   ) u_scale (
      .clock(clock),
      .reset(reset),
      .in_valid(fr_valid),
      .in_stall(fr_stall),
      .in_action(fr_action),
      .num(fr_num),
      .factor(fr_factor),
      .in_base(fr_base),
      .out_valid(sc_valid),
      .out_stall(sc_stall),
      .out_ctl(sc_ctl),
      .out_mag(sc_mag),
      .out_qneg(sc_qneg),
      .out_ovf(sc_ovf),
      .out_dmag(sc_dmag),
      .out_base(sc_base)
   );

   crp_divider #(
      .GROUND_WIDTH(GROUND_WIDTH),
      .ROT_FRAC_BITS(ROT_FRAC_BITS)
   ) u_divider (
      .clock(clock),
      .reset(reset),
      .in_valid(sc_valid),
      .in_stall(sc_stall),
      .in_ctl(sc_ctl),
      .in_mag(sc_mag),
      .in_qneg(sc_qneg),
      .in_ovf(sc_ovf),
      .in_dmag(sc_dmag),
      .in_base(sc_base),
      .out_valid(dv_valid),
      .out_stall(dv_stall),
      .out_ctl(dv_ctl),
      .out_res(dv_res)
   );

   // saturation to the output format and status
   always_comb begin
      lim = dv_ctl.act ? GND_MAX : DET_MAX;
      for (int l = 0; l < 2; l++) begin
         sat[l] = 1'b0;
         clip_w[l] = dv_res[l];
         if (dv_res[l] > lim) begin
            clip_w[l] = lim;
            sat[l] = 1'b1;
         end else if (dv_res[l] < ~lim) begin
            clip_w[l] = ~lim;
            sat[l] = 1'b1;
         end
      end
      if (dv_ctl.den_zero) begin
         rsp_first_in = '0;
         rsp_second_in = '0;
         rsp_status_in = STATUS_ZERO_DEN;
      end else begin
         rsp_first_in = clip_w[0][DET_WIDTH-1:0];
         rsp_second_in = clip_w[1][DET_WIDTH-1:0];
         rsp_status_in = (sat[0] || sat[1]) ? STATUS_SAT : STATUS_OK;
      end
   end

   assign dv_stall = rsp_valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!dv_stall) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!dv_stall) begin
         rsp_first_ff <= rsp_first_in;
         rsp_second_ff <= rsp_second_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_first = $signed(rsp_first_ff);
   assign rsp_result_second = $signed(rsp_second_ff);
   assign rsp_status = rsp_status_ff;

   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled while response side free");

   a_zero_den_outputs: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_ZERO_DEN) |->
         (rsp_result_first == '0 && rsp_result_second == '0))
      else $error("zero denominator with nonzero result");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

// ===== hw/rtl/crp_front.sv =====
module crp_front #(
   parameter int GROUND_WIDTH = crp_pkg::GROUND_WIDTH_DEF,
   parameter int ROT_FRAC_BITS = crp_pkg::ROT_FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_stall,
   input  logic in_action,
   input  logic signed [crp_pkg::DET_WIDTH-1:0] in_first,
   input  logic signed [crp_pkg::DET_WIDTH-1:0] in_second,
   input  logic signed [crp_pkg::DET_WIDTH-1:0] in_height,
   input  logic signed [ROT_FRAC_BITS+1:0] rot [3][3],
   input  logic signed [GROUND_WIDTH-1:0] st_x,
   input  logic signed [GROUND_WIDTH-1:0] st_y,
   input  logic signed [GROUND_WIDTH-1:0] st_z,
   input  logic signed [crp_pkg::PP_WIDTH-1:0] xi0,
   input  logic signed [crp_pkg::PP_WIDTH-1:0] eta0,
   input  logic [crp_pkg::FOCAL_WIDTH-1:0] focal,
   output logic out_valid,
   input  logic out_stall,
   output logic out_action,
   output logic signed [crp_pkg::num_width(GROUND_WIDTH, ROT_FRAC_BITS)-1:0] num [3],
   output logic signed [crp_pkg::fac_width(GROUND_WIDTH)-1:0] factor,
   output logic signed [crp_pkg::base_width(GROUND_WIDTH)-1:0] base [2]
);
   import crp_pkg::*;

   localparam int NS = 3;
   localparam int RW = ROT_FRAC_BITS + 2;
   localparam int DIFW = dif_width(GROUND_WIDTH);
   localparam int FW = fac_width(GROUND_WIDTH);
   localparam int BW = base_width(GROUND_WIDTH);
   localparam int PRW = RW + DIFW;
   localparam int NUMW = num_width(GROUND_WIDTH, ROT_FRAC_BITS);

   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_src;
   logic [NS:0]   stall_w;

   logic [63:0] fx64, fy64, fz64;
   logic signed [GROUND_WIDTH-1:0] gx, gy, gz;

   logic signed [DIFW-1:0] d_in [3];
   logic signed [DIFW-1:0] d_ff [3];
   logic signed [FW-1:0]   f_in;
   logic signed [FW-1:0]   f_ff [NS];
   logic signed [BW-1:0]   base_in [2];
   logic signed [BW-1:0]   base_ff [NS][2];
   logic                   act_ff [NS];

   logic signed [RW-1:0]   coef [3][3];
   logic signed [PRW-1:0]  p_in [3][3];
   logic signed [PRW-1:0]  p_ff [3][3];
   logic signed [NUMW-1:0] num_in [3];
   logic signed [NUMW-1:0] num_ff [3];

   always_comb begin
      stall_w[NS] = out_stall;
      for (int s = NS - 1; s >= 0; s--) begin
         stall_w[s] = v_ff[s] && stall_w[s+1];
      end
   end

   assign in_stall = stall_w[0];
   assign v_src = {v_ff[NS-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int s = 0; s < NS; s++) begin
            if (!stall_w[s]) begin
               v_ff[s] <= v_src[s];
            end
         end
      end
   end

   // stage 0: differences, factor and base
   always_comb begin
      fx64 = {{(64-DET_WIDTH){1'b0}}, in_first};
      fy64 = {{(64-DET_WIDTH){1'b0}}, in_second};
      fz64 = {{(64-DET_WIDTH){1'b0}}, in_height};
      gx = $signed(fx64[GROUND_WIDTH-1:0]);
      gy = $signed(fy64[GROUND_WIDTH-1:0]);
      gz = $signed(fz64[GROUND_WIDTH-1:0]);
      if (!in_action) begin
         d_in[0] = DIFW'(gx) - DIFW'(st_x);
         d_in[1] = DIFW'(gy) - DIFW'(st_y);
         d_in[2] = DIFW'(gz) - DIFW'(st_z);
         f_in = FW'($signed({1'b0, focal}));
         base_in[0] = BW'(xi0);
         base_in[1] = BW'(eta0);
      end else begin
         d_in[0] = DIFW'(in_first) - DIFW'(xi0);
         d_in[1] = DIFW'(in_second) - DIFW'(eta0);
         d_in[2] = -DIFW'($signed({1'b0, focal}));
         f_in = FW'(gz) - FW'(st_z);
         base_in[0] = BW'(st_x);
         base_in[1] = BW'(st_y);
      end
   end

   // stage 1: nine products, rotation transposed for projection
   always_comb begin
      for (int n = 0; n < 3; n++) begin
         for (int k = 0; k < 3; k++) begin
            coef[n][k] = act_ff[0] ? rot[n][k] : rot[k][n];
            p_in[n][k] = PRW'(coef[n][k]) * PRW'(d_ff[k]);
         end
      end
   end

   // stage 2: sums
   always_comb begin
      for (int n = 0; n < 3; n++) begin
         num_in[n] = NUMW'(p_ff[n][0]) + NUMW'(p_ff[n][1]) + NUMW'(p_ff[n][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (!stall_w[0]) begin
         d_ff <= d_in;
         f_ff[0] <= f_in;
         base_ff[0] <= base_in;
         act_ff[0] <= in_action;
      end
      if (!stall_w[1]) begin
         p_ff <= p_in;
         f_ff[1] <= f_ff[0];
         base_ff[1] <= base_ff[0];
         act_ff[1] <= act_ff[0];
      end
      if (!stall_w[2]) begin
         num_ff <= num_in;
         f_ff[2] <= f_ff[1];
         base_ff[2] <= base_ff[1];
         act_ff[2] <= act_ff[1];
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_action = act_ff[NS-1];
   assign num = num_ff;
   assign factor = f_ff[NS-1];
   assign base = base_ff[NS-1];

endmodule

// ===== hw/rtl/crp_scale.sv =====
module crp_scale #(
   parameter int GROUND_WIDTH = crp_pkg::GROUND_WIDTH_DEF,
   parameter int ROT_FRAC_BITS = crp_pkg::ROT_FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_stall,
   input  logic in_action,
   input  logic signed [crp_pkg::num_width(GROUND_WIDTH, ROT_FRAC_BITS)-1:0] num [3],
   input  logic signed [crp_pkg::fac_width(GROUND_WIDTH)-1:0] factor,
   input  logic signed [crp_pkg::base_width(GROUND_WIDTH)-1:0] in_base [2],
   output logic out_valid,
   input  logic out_stall,
   output crp_pkg::ctl_type out_ctl,
   output logic [crp_pkg::prod_width(GROUND_WIDTH, ROT_FRAC_BITS)-1:0] out_mag [2],
   output logic out_qneg [2],
   output logic out_ovf [2],
   output logic [crp_pkg::num_width(GROUND_WIDTH, ROT_FRAC_BITS)-1:0] out_dmag,
   output logic signed [crp_pkg::base_width(GROUND_WIDTH)-1:0] out_base [2]
);
   import crp_pkg::*;

   localparam int NS = 4;
   localparam int NUMW = num_width(GROUND_WIDTH, ROT_FRAC_BITS);
   localparam int PW = prod_width(GROUND_WIDTH, ROT_FRAC_BITS);
   localparam int BW = base_width(GROUND_WIDTH);
   localparam int QB = quo_width(GROUND_WIDTH);
   localparam int CW = cmp_width(GROUND_WIDTH, ROT_FRAC_BITS);
   localparam int LOW = NUMW / 2;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_src;
   logic [NS:0]   stall_w;

   logic                 act_ff [NS];
   logic                 dz_ff [NS];
   logic                 dneg_ff [NS];
   logic [NUMW-1:0]      dmag_ff [NS];
   logic signed [BW-1:0] base_ff [NS][2];

   logic signed [PW-1:0] pp_lo_in [2], pp_hi_in [2];
   logic signed [PW-1:0] pp_lo_ff [2], pp_hi_ff [2];
   logic signed [PW-1:0] prod_in [2], prod_ff [2];
   logic [PW-1:0]        mag_in [2], mag_ff [NS][2];
   logic                 qneg_in [2], qneg_ff [NS][2];
   logic                 ovf_in [2], ovf_ff [2];
   logic [NUMW-1:0]      dmag_in;

   always_comb begin
      stall_w[NS] = out_stall;
      for (int s = NS - 1; s >= 0; s--) begin
         stall_w[s] = v_ff[s] && stall_w[s+1];
      end
   end

   assign in_stall = stall_w[0];
   assign v_src = {v_ff[NS-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int s = 0; s < NS; s++) begin
            if (!stall_w[s]) begin
               v_ff[s] <= v_src[s];
            end
         end
      end
   end

   always_comb begin
      dmag_in = num[2][NUMW-1] ? NUMW'(-num[2]) : NUMW'(num[2]);
      for (int l = 0; l < 2; l++) begin
         pp_lo_in[l] = PW'($signed({1'b0, num[l][LOW-1:0]})) * PW'(factor);
         pp_hi_in[l] = PW'($signed(num[l][NUMW-1:LOW])) * PW'(factor);
         prod_in[l] = (pp_hi_ff[l] <<< LOW) + pp_lo_ff[l];
         mag_in[l] = prod_ff[l][PW-1] ? PW'(-prod_ff[l]) : PW'(prod_ff[l]);
         qneg_in[l] = prod_ff[l][PW-1] ^ dneg_ff[1];
         ovf_in[l] = CW'(mag_ff[2][l]) >= (CW'(dmag_ff[2]) << QB);
      end
   end

   always_ff @(posedge clock) begin
      if (!stall_w[0]) begin
         pp_lo_ff <= pp_lo_in;
         pp_hi_ff <= pp_hi_in;
         act_ff[0] <= in_action;
         dz_ff[0] <= (num[2] == '0);
         dneg_ff[0] <= num[2][NUMW-1];
         dmag_ff[0] <= dmag_in;
         base_ff[0] <= in_base;
      end
      if (!stall_w[1]) begin
         prod_ff <= prod_in;
         act_ff[1] <= act_ff[0];
         dz_ff[1] <= dz_ff[0];
         dneg_ff[1] <= dneg_ff[0];
         dmag_ff[1] <= dmag_ff[0];
         base_ff[1] <= base_ff[0];
      end
      if (!stall_w[2]) begin
         mag_ff[2] <= mag_in;
         qneg_ff[2] <= qneg_in;
         act_ff[2] <= act_ff[1];
         dz_ff[2] <= dz_ff[1];
         dneg_ff[2] <= dneg_ff[1];
         dmag_ff[2] <= dmag_ff[1];
         base_ff[2] <= base_ff[1];
      end
      if (!stall_w[3]) begin
         mag_ff[3] <= mag_ff[2];
         qneg_ff[3] <= qneg_ff[2];
         ovf_ff <= ovf_in;
         act_ff[3] <= act_ff[2];
         dz_ff[3] <= dz_ff[2];
         dneg_ff[3] <= dneg_ff[2];
         dmag_ff[3] <= dmag_ff[2];
         base_ff[3] <= base_ff[2];
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_ctl = '{act: act_ff[NS-1], den_zero: dz_ff[NS-1]};
   assign out_mag = mag_ff[NS-1];
   assign out_qneg = qneg_ff[NS-1];
   assign out_ovf = ovf_ff;
   assign out_dmag = dmag_ff[NS-1];
   assign out_base = base_ff[NS-1];

endmodule

// ===== hw/rtl/crp_divider.sv =====
module crp_divider #(
   parameter int GROUND_WIDTH = crp_pkg::GROUND_WIDTH_DEF,
   parameter int ROT_FRAC_BITS = crp_pkg::ROT_FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_stall,
   input  crp_pkg::ctl_type in_ctl,
   input  logic [crp_pkg::prod_width(GROUND_WIDTH, ROT_FRAC_BITS)-1:0] in_mag [2],
   input  logic in_qneg [2],
   input  logic in_ovf [2],
   input  logic [crp_pkg::num_width(GROUND_WIDTH, ROT_FRAC_BITS)-1:0] in_dmag,
   input  logic signed [crp_pkg::base_width(GROUND_WIDTH)-1:0] in_base [2],
   output logic out_valid,
   input  logic out_stall,
   output crp_pkg::ctl_type out_ctl,
   output logic signed [crp_pkg::res_width(GROUND_WIDTH)-1:0] out_res [2]
);
   import crp_pkg::*;

   localparam int NUMW = num_width(GROUND_WIDTH, ROT_FRAC_BITS);
   localparam int PW = prod_width(GROUND_WIDTH, ROT_FRAC_BITS);
   localparam int BW = base_width(GROUND_WIDTH);
   localparam int QB = quo_width(GROUND_WIDTH);
   localparam int CW = cmp_width(GROUND_WIDTH, ROT_FRAC_BITS);
   localparam int RSW = res_width(GROUND_WIDTH);
   localparam int NS = QB + 1;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_src;
   logic [NS:0]   stall_w;

   logic [PW-1:0]        r_src [QB][2], r_in [QB][2], r_ff [QB][2];
   logic [QB-1:0]        q_src [QB][2], q_in [QB][2], q_ff [QB][2];
   logic [NUMW-1:0]      d_src [QB], d_ff [QB];
   logic                 neg_src [QB][2], neg_ff [QB][2];
   logic                 ovf_src [QB][2], ovf_ff [QB][2];
   logic signed [BW-1:0] base_src [QB][2], base_ff [QB][2];
   ctl_type              ctl_src [QB], ctl_ff [QB];

   logic [CW-1:0]        dsh [QB];
   logic [CW-1:0]        rext [QB][2];
   logic                 ge [QB][2];

   logic                  up [2];
   logic [QB:0]           qf [2];
   logic                  rneg [2];
   logic signed [RSW-1:0] sqv [2];
   logic signed [RSW-1:0] res_in [2], res_ff [2];
   ctl_type               ctl_out_ff;

   always_comb begin
      stall_w[NS] = out_stall;
      for (int s = NS - 1; s >= 0; s--) begin
         stall_w[s] = v_ff[s] && stall_w[s+1];
      end
   end

   assign in_stall = stall_w[0];
   assign v_src = {v_ff[NS-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int s = 0; s < NS; s++) begin
            if (!stall_w[s]) begin
               v_ff[s] <= v_src[s];
            end
         end
      end
   end

   // one quotient bit per stage, most significant first
   always_comb begin
      for (int s = 0; s < QB; s++) begin
         if (s == 0) begin
            r_src[s] = in_mag;
            q_src[s][0] = '0;
            q_src[s][1] = '0;
            d_src[s] = in_dmag;
            neg_src[s] = in_qneg;
            ovf_src[s] = in_ovf;
            base_src[s] = in_base;
            ctl_src[s] = in_ctl;
         end else begin
            r_src[s] = r_ff[s-1];
            q_src[s] = q_ff[s-1];
            d_src[s] = d_ff[s-1];
            neg_src[s] = neg_ff[s-1];
            ovf_src[s] = ovf_ff[s-1];
            base_src[s] = base_ff[s-1];
            ctl_src[s] = ctl_ff[s-1];
         end
         dsh[s] = CW'(d_src[s]) << (QB - 1 - s);
         for (int l = 0; l < 2; l++) begin
            rext[s][l] = CW'(r_src[s][l]);
            ge[s][l] = rext[s][l] >= dsh[s];
            r_in[s][l] = ge[s][l] ? PW'(rext[s][l] - dsh[s]) : r_src[s][l];
            q_in[s][l] = q_src[s][l];
            q_in[s][l][QB-1-s] = ge[s][l];
         end
      end
   end

   // rounding, sign and base offset
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         up[l] = {r_ff[QB-1][l][NUMW-1:0], 1'b0} >= {1'b0, d_ff[QB-1]};
         qf[l] = ovf_ff[QB-1][l] ? {1'b1, {QB{1'b0}}}
                                 : ({1'b0, q_ff[QB-1][l]} + (QB+1)'(up[l]));
         rneg[l] = neg_ff[QB-1][l] ^ !ctl_ff[QB-1].act;
         sqv[l] = RSW'($signed({1'b0, qf[l]}));
         res_in[l] = RSW'(base_ff[QB-1][l]) + (rneg[l] ? -sqv[l] : sqv[l]);
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < QB; s++) begin
         if (!stall_w[s]) begin
            r_ff[s] <= r_in[s];
            q_ff[s] <= q_in[s];
            d_ff[s] <= d_src[s];
            neg_ff[s] <= neg_src[s];
            ovf_ff[s] <= ovf_src[s];
            base_ff[s] <= base_src[s];
            ctl_ff[s] <= ctl_src[s];
         end
      end
      if (!stall_w[QB]) begin
         res_ff <= res_in;
         ctl_out_ff <= ctl_ff[QB-1];
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_ctl = ctl_out_ff;
   assign out_res = res_ff;

endmodule
